/* design/rn_pkg.sv */
// ----------------------------------------------------------------------------
// rn_pkg: shared types for the rational normalizer
// Sequencer states used by the top level and its assertions.
// ----------------------------------------------------------------------------
`default_nettype none

package rn_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* design/rational_normalize.sv */
// ----------------------------------------------------------------------------
// rational_normalize: reduce a signed fraction to lowest terms
// Binary GCD followed by two restoring divisions on one shared subtractor.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_num_in / req_den_in and pulse start while busy is low; the
//   item is taken at that clock edge and busy rises on the next cycle.
//   Once the item is done, rsp_valid is high for exactly one
//   cycle with rsp_num_out / rsp_den_out; busy falls the cycle after.
//   The receiver cannot stall the result, so nothing is held back.
// Sequence:
//   A zero operand gives 0/1; the sequencer goes from accept straight to
//   the result. Otherwise: binary GCD (one step per cycle on the shared
//   subtractor, operand swaps included), then the two bit-serial divisions
//   on the same subtractor; one item at a time, busy meanwhile.
// Reset:
//   Synchronous active-high reset returns the sequencer to idle; any
//   item in flight is dropped. The datapath registers have no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_normalize #(
   parameter int WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [WIDTH-1:0] req_num_in,
   input  wire logic signed [WIDTH-1:0] req_den_in,
   output logic                         rsp_valid,
   output logic signed      [WIDTH-1:0] rsp_num_out,
   output logic             [WIDTH-2:0] rsp_den_out
);
   import rn_pkg::*;

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   state_type state_ff, state_in;

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] nm_ff, nm_in;
   logic [WIDTH-1:0] dm_ff, dm_in;
   logic [WIDTH-1:0] g_ff, g_in;
   logic [WIDTH-1:0] q_ff, q_in;
   logic [WIDTH-2:0] rem_ff, rem_in;
   logic [WIDTH-1:0] rn_ff, rn_in;
   logic [CW-1:0]    k_ff, k_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             sign_ff, sign_in;
   logic             zero_ff, zero_in;

   logic [WIDTH-1:0] num_mag;
   logic [WIDTH-1:0] den_mag;
   logic [WIDTH-1:0] alu_x;
   logic [WIDTH-1:0] alu_y;
   logic [WIDTH-1:0] alu_diff;
   logic             alu_borrow;
   logic             alu_equal;
   logic [WIDTH-1:0] div_x;
   logic             accept;
   logic             gcd_done;
   logic             div_last;

   assign accept   = start && !busy;
   assign num_mag  = req_num_in[WIDTH-1] ? (~req_num_in + 1'b1) : req_num_in;
   assign den_mag  = req_den_in[WIDTH-1] ? (~req_den_in + 1'b1) : req_den_in;
   assign div_x    = {rem_ff, q_ff[WIDTH-1]};
   assign gcd_done = (state_ff == ST_GCD) && alu_equal;
   assign div_last = (cnt_ff == LAST);

   always_comb begin
      if (state_ff == ST_GCD) begin
         alu_x = a_ff;
         alu_y = b_ff;
      end else begin
         alu_x = div_x;
         alu_y = g_ff;
      end
   end

   rn_alu #(
      .WIDTH (WIDTH)
   ) u_alu (
      .x      (alu_x),
      .y      (alu_y),
      .diff   (alu_diff),
      .borrow (alu_borrow),
      .equal  (alu_equal)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (num_mag == '0 || den_mag == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (alu_equal) begin
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_last) begin
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      nm_in   = nm_ff;
      dm_in   = dm_ff;
      g_in    = g_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      rn_in   = rn_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      sign_in = sign_ff;
      zero_in = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in    = num_mag;
               b_in    = den_mag;
               nm_in   = num_mag;
               dm_in   = den_mag;
               k_in    = '0;
               sign_in = req_num_in[WIDTH-1] ^ req_den_in[WIDTH-1];
               zero_in = (num_mag == '0) || (den_mag == '0);
            end
         end
         ST_GCD: begin
            priority if (alu_equal) begin
               g_in   = a_ff << k_ff;
               q_in   = nm_ff;
               rem_in = '0;
               cnt_in = '0;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (alu_borrow) begin
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               a_in = alu_diff >> 1;
            end
         end
         ST_DIVN, ST_DIVD: begin
            q_in   = {q_ff[WIDTH-2:0], !alu_borrow};
            rem_in = alu_borrow ? div_x[WIDTH-2:0] : alu_diff[WIDTH-2:0];
            cnt_in = cnt_ff + 1'b1;
            if (div_last && state_ff == ST_DIVN) begin
               rn_in  = {q_ff[WIDTH-2:0], !alu_borrow};
               q_in   = dm_ff;
               rem_in = '0;
               cnt_in = '0;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      if (zero_ff) begin
         rsp_num_out = '0;
         rsp_den_out = (WIDTH-1)'(1);
      end else begin
         if (sign_ff) begin
            rsp_num_out = ~rn_ff + 1'b1;
         end else if (rn_ff[WIDTH-1]) begin
            rsp_num_out = {1'b0, {(WIDTH-1){1'b1}}};
         end else begin
            rsp_num_out = rn_ff;
         end
         rsp_den_out = q_ff[WIDTH-1] ? {(WIDTH-1){1'b1}} : q_ff[WIDTH-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      g_ff    <= g_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      rn_ff   <= rn_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      sign_ff <= sign_in;
      zero_ff <= zero_in;
   end

`ifndef NO_ASSERTIONS
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_den_out != '0)
      else $error("zero denominator on result");

   a_zero_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_num_out == '0) |-> rsp_den_out == (WIDTH-1)'(1))
      else $error("zero numerator without unit denominator");

   a_gcd_operands: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> (a_ff != '0 && b_ff != '0))
      else $error("gcd operand reached zero");

   a_gcd_to_div: assert property (@(posedge clock) disable iff (reset)
      gcd_done |=> (state_ff == ST_DIVN && cnt_ff == '0 && g_ff != '0))
      else $error("divide phase not set up after gcd");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe not followed by idle");
`endif

endmodule

`default_nettype wire

/* design/rn_alu.sv */
// ----------------------------------------------------------------------------
// rn_alu: shared subtract and compare unit
// Computes x - y with borrow and equality; used by both the GCD and divide
// steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rn_alu #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0] x,
   input  wire logic [WIDTH-1:0] y,
   output logic      [WIDTH-1:0] diff,
   output logic                  borrow,
   output logic                  equal
);
   import rn_pkg::*;

   logic [WIDTH:0] full;

   assign full   = {1'b0, x} - {1'b0, y};
   assign diff   = full[WIDTH-1:0];
   assign borrow = full[WIDTH];
   assign equal  = (full == '0);

endmodule

`default_nettype wire

/* verif/rn_fraction_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rn_fraction_check: scoreboard for the rational normalizer
// Watches the request and result channels, reduces every accepted fraction
// to lowest terms on its own and compares each result, field by field, with
// the oldest pending fraction. Mismatch count goes back to the top.
// ----------------------------------------------------------------------------
module rn_fraction_check #(
   parameter int WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic                    busy,
   input  wire logic signed [WIDTH-1:0] req_num_in,
   input  wire logic signed [WIDTH-1:0] req_den_in,
   input  wire logic                    rsp_valid,
   input  wire logic signed [WIDTH-1:0] rsp_num_out,
   input  wire logic        [WIDTH-2:0] rsp_den_out,
   output int                           mismatches,
   output int                           outstanding
);

   localparam logic [WIDTH-1:0] MAG_LIMIT = {1'b0, {(WIDTH-1){1'b1}}};
   localparam int               PRINT_CAP = 100;

   typedef struct packed {
      logic signed [WIDTH-1:0] op_num;
      logic signed [WIDTH-1:0] op_den;
      logic signed [WIDTH-1:0] num;
      logic        [WIDTH-2:0] den;
   } fraction_type;

   fraction_type reduced_fractions[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // magnitudes are taken as W-bit unsigned, so the most negative value
   // keeps its true size; results that do not fit saturate
   function automatic fraction_type lowest_terms(logic signed [WIDTH-1:0] n,
                                                 logic signed [WIDTH-1:0] d);
      logic [WIDTH-1:0] nm, dm, a, b, r, rn, rd;
      fraction_type     f;
      f.op_num = n;
      f.op_den = d;
      f.num    = '0;
      f.den    = (WIDTH-1)'(1);
      nm = n[WIDTH-1] ? ~n + 1'b1 : n;
      dm = d[WIDTH-1] ? ~d + 1'b1 : d;
      if (nm == 0 || dm == 0) begin
         return f;
      end
      a = nm;
      b = dm;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      rn = nm / a;
      rd = dm / a;
      if (rd > MAG_LIMIT) begin
         rd = MAG_LIMIT;
      end
      if (n[WIDTH-1] != d[WIDTH-1]) begin
         f.num = ~rn + 1'b1;
      end else begin
         if (rn > MAG_LIMIT) begin
            rn = MAG_LIMIT;
         end
         f.num = rn;
      end
      f.den = rd[WIDTH-2:0];
      return f;
   endfunction

   task automatic report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin : monitor
      fraction_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (reduced_fractions.size() == 0) begin
               report($sformatf("unexpected result %0d/%0d", rsp_num_out, rsp_den_out));
            end else begin
               want = reduced_fractions.pop_front();
               if (rsp_num_out !== want.num) begin
                  report($sformatf("num_out for %0d/%0d: got %0d, want %0d",
                                   want.op_num, want.op_den, rsp_num_out, want.num));
               end
               if (rsp_den_out !== want.den) begin
                  report($sformatf("den_out for %0d/%0d: got %0d, want %0d",
                                   want.op_num, want.op_den, rsp_den_out, want.den));
               end
            end
         end
         if (start && !busy) begin
            reduced_fractions.push_back(lowest_terms(req_num_in, req_den_in));
         end
      end
      outstanding <= reduced_fractions.size();
   end

endmodule

/* verif/tb_rational_normalize.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_normalize: top of the rational normalizer testbench
// Resets the block, sends a directed set of fractions (zeros, extremes,
// sign combinations, coprime and shared-factor pairs), then random fractions
// with random gaps between items. Checking is done by rn_fraction_check.
// ----------------------------------------------------------------------------
module tb_rational_normalize;

   localparam int          WIDTH        = 32;
   localparam int          RANDOM_ITEMS = 800;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 200;
   localparam int unsigned MAX_MAG      = 32'h7FFF_FFFF;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    start      = 1'b0;
   logic signed [WIDTH-1:0] req_num_in = '0;
   logic signed [WIDTH-1:0] req_den_in = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic signed [WIDTH-1:0] rsp_num_out;
   logic        [WIDTH-2:0] rsp_den_out;
   int                      mismatches;
   int                      outstanding;
   int                      cycles     = 0;
   bit                      quiet_sender = 1'b0;

   rational_normalize #(.WIDTH(WIDTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_num_in  (req_num_in),
      .req_den_in  (req_den_in),
      .rsp_valid   (rsp_valid),
      .rsp_num_out (rsp_num_out),
      .rsp_den_out (rsp_den_out)
   );

   rn_fraction_check #(.WIDTH(WIDTH)) SB (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_num_in  (req_num_in),
      .req_den_in  (req_den_in),
      .rsp_valid   (rsp_valid),
      .rsp_num_out (rsp_num_out),
      .rsp_den_out (rsp_den_out),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_rational_normalize NOT OK");
         $finish;
      end
   end

   task automatic send_fraction(logic signed [WIDTH-1:0] n, logic signed [WIDTH-1:0] d);
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_num_in <= n;
      req_den_in <= d;
      do @(posedge clock); while (busy);
   endtask

   // full-range value, most negative code excluded
   function automatic logic signed [WIDTH-1:0] any_value();
      logic [WIDTH-1:0] v;
      do v = $urandom; while (v == {1'b1, {(WIDTH-1){1'b0}}});
      return v;
   endfunction

   function automatic logic signed [WIDTH-1:0] with_sign(int unsigned m);
      logic signed [WIDTH-1:0] v;
      v = m;
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   initial begin : stimulus
      int unsigned             g, a, b;
      logic signed [WIDTH-1:0] n, d;
      logic signed [WIDTH-1:0] pmax;
      pmax = MAX_MAG;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_fraction(0, 0);
      send_fraction(0, 7);
      send_fraction(-9, 0);
      send_fraction(pmax, pmax);
      send_fraction(-pmax, pmax);
      send_fraction(pmax, -pmax);
      send_fraction(-pmax, -pmax);
      send_fraction(1, 1);
      send_fraction(-1, 1);
      send_fraction(1, -1);
      send_fraction(-1, -1);
      send_fraction(pmax, 1);
      send_fraction(1, pmax);
      send_fraction(-pmax, 1);
      send_fraction(1, -pmax);
      send_fraction(6, -4);
      send_fraction(-12, -18);
      send_fraction(pmax, pmax - 1);
      send_fraction(1 << 30, 1 << 20);
      send_fraction(-(1 << 30), 3 << 20);
      send_fraction(1431655765, -715827882);
      send_fraction(1000000007, 998244353);
      send_fraction(-(1 << 30), -pmax);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            quiet_sender = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = any_value();
               d = any_value();
            end
            3, 4, 5: begin
               g = $urandom_range(1, 1 << $urandom_range(1, 20));
               a = $urandom_range(1, MAX_MAG / g);
               b = $urandom_range(1, MAX_MAG / g);
               n = with_sign(a * g);
               d = with_sign(b * g);
            end
            6: begin
               n = with_sign($urandom_range(1, 1000) << $urandom_range(0, 20));
               d = with_sign($urandom_range(1, 1000) << $urandom_range(0, 20));
            end
            7: begin
               n = with_sign($urandom_range(0, 50));
               d = with_sign($urandom_range(0, 50));
            end
            8: begin
               n = $urandom_range(0, 1) ? any_value() : '0;
               d = (n == 0) ? any_value() : '0;
            end
            default: begin
               a = $urandom_range(1, 100000);
               b = $urandom_range(1, 20000);
               n = with_sign(a * b);
               d = with_sign(a);
               if ($urandom_range(0, 1)) begin
                  {n, d} = {d, n};
               end
            end
         endcase
         send_fraction(n, d);
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_rational_normalize OK");
      end else begin
         $display("tb_rational_normalize NOT OK");
      end
      $finish;
   end

endmodule
